// ===== src/vnu_pkg.sv =====
// Shared types and constants for the vector normalize unit.
`timescale 1ns / 1ps
package vnu_pkg;

	localparam int LANES       = 4;
	localparam int SQRT_CELLS  = 32;
	localparam int DIV_CELLS   = 32;

	// Payload that rides along the square root chain.
	typedef struct packed {
		logic [LANES-1:0][31:0] mag;
		logic [LANES-1:0]       neg;
		logic [4:0]             h;
		logic                   zero;
		logic                   full;
	} sq_pay_t;

	// One square root cell's state: radicand bits still to consume, remainder, root.
	typedef struct packed {
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
		sq_pay_t     pay;
	} sq_st_t;

	// One divider cell's state for all lanes.
	typedef struct packed {
		logic [LANES-1:0][32:0] rem;
		logic [LANES-1:0][31:0] q;
		logic [31:0]            r;
		logic [LANES-1:0]       neg;
		logic [32:0]            magn;
		logic                   zero;
		logic                   full;
	} dv_st_t;

endpackage

// ===== src/vnu_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
`timescale 1ns / 1ps
module vnu_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  vnu_pkg::sq_st_t in_st,
	output logic            out_valid,
	output vnu_pkg::sq_st_t out_st
);

	logic [35:0]     cur;
	logic [35:0]     trial;
	logic            take;
	logic [35:0]     rem_n;
	vnu_pkg::sq_st_t nxt;

	always_comb begin
		cur   = {in_st.rem, in_st.rad[63:62]};
		trial = {2'b00, in_st.root, 2'b01};
		take  = (cur >= trial);
		rem_n = take ? (cur - trial) : cur;
		nxt      = in_st;
		nxt.rad  = {in_st.rad[61:0], 2'b00};
		nxt.rem  = rem_n[33:0];
		nxt.root = {in_st.root[30:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_st <= nxt;
		end
	end

endmodule

// ===== src/vnu_div_cell.sv =====
// One quotient-bit cell of the pipelined divider, all lanes side by side.
`timescale 1ns / 1ps
module vnu_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  vnu_pkg::dv_st_t in_st,
	output logic            out_valid,
	output vnu_pkg::dv_st_t out_st
);

	vnu_pkg::dv_st_t nxt;
	logic [32:0]     diff;
	logic            take;

	always_comb begin
		nxt = in_st;
		diff = '0;
		take = 1'b0;
		for (int i = 0; i < vnu_pkg::LANES; i++) begin
			take = (in_st.rem[i] >= {1'b0, in_st.r});
			diff = take ? (in_st.rem[i] - {1'b0, in_st.r}) : in_st.rem[i];
			// The remainder stays below the divisor, so 32 bits survive the shift.
			nxt.rem[i] = {diff[31:0], 1'b0};
			nxt.q[i]   = {in_st.q[i][30:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_st <= nxt;
		end
	end

endmodule

// ===== src/vector_normalize_unit.sv =====
// Top level of the vector normalize unit.
`timescale 1ns / 1ps
// Usage:
// A word on s_tdata carries four signed Q16.16 components, x in the lowest
// 32 bits. Each word yields one result word on m_tdata: four signed Q1.30
// unit components and a 33-bit unsigned Q17.16 length; m_tuser[0] flags a
// vector whose used components are all zero (unit outputs are then zero).
// cfg_we/cfg_wdata set the dimension (2, 3 or 4; reset 4) and may only be
// written while the unit is empty. Unused components read as zero.
// Throughput is one word per cycle while the receiver keeps up. Four front
// stages (magnitude, squares, sum, normalize), 32 square root cells, one
// rescale stage, 32 divider cells and the output register form the pipeline.
// Every stage advances when it is empty or the stage after it advances,
// so bubbles close up and input is taken while a result waits on a stalled
// receiver; once every stage is full, s_tready drops until m_tready rises.
// Reset empties the pipeline and sets the dimension to 4.
module vector_normalize_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // comp_x, comp_y, comp_z, comp_w
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,   // unit_x, unit_y, unit_z, unit_w, magnitude, zero pad
	output logic [0:0]   m_tuser    // zero_vector
);

	localparam int NSQ   = vnu_pkg::SQRT_CELLS;
	localparam int NDV   = vnu_pkg::DIV_CELLS;
	localparam int SQ0   = 4;
	localparam int POST  = SQ0 + NSQ;
	localparam int DV0   = POST + 1;
	localparam int OUTI  = DV0 + NDV;
	localparam int NST   = OUTI + 1;

	logic [NST-1:0] v;
	logic [NST-1:0] adv;

	logic [2:0] dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 3'd4;
		end else if (cfg_we) begin
			dim_q <= cfg_wdata;
		end
	end

	assign adv[NST-1] = !v[NST-1] || m_tready;
	genvar g;
	generate
		for (g = 0; g < NST-1; g++) begin : g_adv
			assign adv[g] = !v[g] || adv[g+1];
		end
	endgenerate
	assign s_tready = adv[0];

	// Stage 1: magnitudes and signs, unused lanes forced to zero.
	logic [3:0][31:0] mag_s1;
	logic [3:0]       neg_s1;
	logic [3:0]       use_lane;
	assign use_lane = {dim_q >= 3'd4, dim_q >= 3'd3, 2'b11};

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < 4; i++) begin
				neg_s1[i] <= use_lane[i] & s_tdata[32*i+31];
				mag_s1[i] <= !use_lane[i] ? 32'd0 :
					(s_tdata[32*i+31] ? (32'd0 - s_tdata[32*i +: 32]) : s_tdata[32*i +: 32]);
			end
		end
	end

	// Stage 2: squares.
	logic [3:0][63:0] sq_s2;
	logic [3:0][31:0] mag_s2;
	logic [3:0]       neg_s2;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: exact 65-bit sum of squares.
	logic [64:0]      sum_s3;
	logic [3:0][31:0] mag_s3;
	logic [3:0]       neg_s3;
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sum_s3 <= 65'(sq_s2[0]) + 65'(sq_s2[1]) + 65'(sq_s2[2]) + 65'(sq_s2[3]);
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: even normalizing shift that puts the top pair of bits at 63:62.
	logic [4:0]      h_c;
	vnu_pkg::sq_st_t sq_in_s4;
	always_comb begin
		h_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (sum_s3[2*i +: 2] != 2'b00) begin
				h_c = 5'(31 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sq_in_s4.rad      <= sum_s3[63:0] << {h_c, 1'b0};
			sq_in_s4.rem      <= '0;
			sq_in_s4.root     <= '0;
			sq_in_s4.pay.mag  <= mag_s3;
			sq_in_s4.pay.neg  <= neg_s3;
			sq_in_s4.pay.h    <= h_c;
			sq_in_s4.pay.zero <= (sum_s3 == 65'd0);
			sq_in_s4.pay.full <= sum_s3[64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
			v[1] <= 1'b0;
			v[2] <= 1'b0;
			v[3] <= 1'b0;
		end else begin
			if (adv[0]) v[0] <= s_tvalid;
			if (adv[1]) v[1] <= v[0];
			if (adv[2]) v[2] <= v[1];
			if (adv[3]) v[3] <= v[2];
		end
	end

	// Square root chain.
	vnu_pkg::sq_st_t sq_st [0:NSQ];
	assign sq_st[0] = sq_in_s4;
	generate
		for (g = 0; g < NSQ; g++) begin : g_sq
			vnu_sqrt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv[SQ0+g]),
				.in_valid  (v[SQ0+g-1]),
				.in_st     (sq_st[g]),
				.out_valid (v[SQ0+g]),
				.out_st    (sq_st[g+1])
			);
		end
	endgenerate

	// Rescale stage: length from the shifted root, scaled components for division.
	vnu_pkg::sq_st_t sq_last;
	vnu_pkg::dv_st_t dv_in_s5;
	assign sq_last = sq_st[NSQ];

	always_ff @(posedge clk) begin
		if (adv[POST]) begin
			for (int i = 0; i < 4; i++) begin
				dv_in_s5.rem[i] <= {1'b0, 32'(64'(sq_last.pay.mag[i]) << sq_last.pay.h)};
				dv_in_s5.q[i]   <= '0;
			end
			dv_in_s5.r    <= sq_last.root;
			dv_in_s5.neg  <= sq_last.pay.neg;
			dv_in_s5.zero <= sq_last.pay.zero;
			dv_in_s5.full <= sq_last.pay.full;
			dv_in_s5.magn <= sq_last.pay.full ? {1'b1, 32'd0} :
				(sq_last.pay.zero ? 33'd0 : {1'b0, sq_last.root >> sq_last.pay.h});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[POST] <= 1'b0;
		end else if (adv[POST]) begin
			v[POST] <= v[POST-1];
		end
	end

	// Divider chain.
	vnu_pkg::dv_st_t dv_st [0:NDV];
	assign dv_st[0] = dv_in_s5;
	generate
		for (g = 0; g < NDV; g++) begin : g_dv
			vnu_div_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv[DV0+g]),
				.in_valid  (v[DV0+g-1]),
				.in_st     (dv_st[g]),
				.out_valid (v[DV0+g]),
				.out_st    (dv_st[g+1])
			);
		end
	endgenerate

	// Output register: rounding, sign and the special cases.
	vnu_pkg::dv_st_t  dv_last;
	logic [3:0][31:0] unit_c;
	logic [31:0]      qr;
	assign dv_last = dv_st[NDV];

	always_comb begin
		qr = '0;
		for (int i = 0; i < 4; i++) begin
			qr = 32'((33'(dv_last.q[i]) + 33'd1) >> 1);
			if (dv_last.full) begin
				unit_c[i] = 32'hE000_0000;
			end else if (dv_last.zero) begin
				unit_c[i] = '0;
			end else begin
				unit_c[i] = dv_last.neg[i] ? (32'd0 - qr) : qr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[OUTI]) begin
			m_tdata <= {7'd0, dv_last.magn, unit_c[3], unit_c[2], unit_c[1], unit_c[0]};
			m_tuser <= dv_last.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[OUTI] <= 1'b0;
		end else if (adv[OUTI]) begin
			v[OUTI] <= v[OUTI-1];
		end
	end
	assign m_tvalid = v[OUTI];

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

	a_zero_has_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[160:128] == 33'd0 && m_tdata[127:0] == 128'd0))
		else $error("zero vector with nonzero length or unit components");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[160] && m_tdata[159:128] != 32'd0))
		else $error("length above full scale");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[167:161] == 7'd0))
		else $error("output padding not zero");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the vector normalize unit with a scoreboard class.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic [31:0] ux, uy, uz, uw;
		logic [32:0] len;
		logic        zero;
	} unit_vec_t;

	// Integer square root of a 64-bit value, floor.
	function automatic logic [63:0] floor_sqrt(logic [63:0] s);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'h1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	class normalize_scoreboard;
		unit_vec_t pending[$];
		int        errors;
		logic [2:0] dim_reg;

		function new();
			errors = 0;
			dim_reg = 3'd4;
		endfunction

		function void note_vector(logic [127:0] data);
			unit_vec_t   e;
			logic [31:0] mag[4];
			logic        neg[4];
			logic [31:0] res[4];
			logic [64:0] sum;
			logic [63:0] shifted;
			logic [63:0] r;
			logic [127:0] num;
			logic [127:0] q;
			int          dim;
			int          hs;
			logic [31:0] c;
			dim = (dim_reg < 2) ? 2 : (dim_reg > 4) ? 4 : dim_reg;
			sum = 0;
			for (int i = 0; i < 4; i++) begin
				c = data[32*i +: 32];
				mag[i] = 0;
				neg[i] = 0;
				res[i] = 0;
				if (i < dim) begin
					neg[i] = c[31];
					mag[i] = c[31] ? (~c + 32'd1) : c;
					sum = sum + {1'b0, 32'd0, mag[i]} * mag[i];
				end
			end
			e.zero = 0;
			e.len = 0;
			if (sum[64]) begin
				for (int i = 0; i < 4; i++)
					res[i] = -32'sd536870912;
				e.len = 33'h1_0000_0000;
			end else if (sum == 0) begin
				e.zero = 1;
			end else begin
				e.len = 33'(floor_sqrt(sum[63:0]));
				shifted = sum[63:0];
				hs = 0;
				while (shifted[63:62] == 2'b00) begin
					shifted = shifted << 2;
					hs++;
				end
				r = floor_sqrt(shifted);
				for (int i = 0; i < dim; i++) begin
					num = ({96'd0, mag[i]} << hs) << 31;
					q = ((num / r) + 1) >> 1;
					res[i] = neg[i] ? (32'd0 - q[31:0]) : q[31:0];
				end
			end
			e.ux = res[0];
			e.uy = res[1];
			e.uz = res[2];
			e.uw = res[3];
			pending.push_back(e);
		endfunction

		task check_result(logic [167:0] data, logic zflag);
			unit_vec_t e;
			if (pending.size() == 0) begin
				report_mismatch("result with no vector outstanding");
				return;
			end
			e = pending.pop_front();
			if (data[31:0] !== e.ux)
				report_mismatch($sformatf("unit_x %h, want %h", data[31:0], e.ux));
			if (data[63:32] !== e.uy)
				report_mismatch($sformatf("unit_y %h, want %h", data[63:32], e.uy));
			if (data[95:64] !== e.uz)
				report_mismatch($sformatf("unit_z %h, want %h", data[95:64], e.uz));
			if (data[127:96] !== e.uw)
				report_mismatch($sformatf("unit_w %h, want %h", data[127:96], e.uw));
			if (data[160:128] !== e.len)
				report_mismatch($sformatf("magnitude %h, want %h", data[160:128], e.len));
			if (zflag !== e.zero)
				report_mismatch($sformatf("zero_vector %b, want %b", zflag, e.zero));
		endtask

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t: mismatch: %s", $realtime, msg);
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_wdata = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [127:0] s_tdata = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [167:0] m_tdata;
	logic [0:0]   m_tuser;

	normalize_scoreboard board = new();
	bit  calm = 0;         // no idling on either side while set
	bit  hold = 0;         // receiver holds off while set
	bit  stim_done = 0;

	always #2 clk = ~clk;

	vector_normalize_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tuser[0]);
			if (hold) begin
				m_tready <= 0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 17);
			end
		end
	end

	task automatic send_vector(logic [127:0] data);
		s_tvalid <= 1;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_vector(data);
		if (!calm && $urandom_range(99) < 20) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic set_dimension(logic [2:0] d);
		s_tvalid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 0;
		board.dim_reg = d;
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return $urandom_range(1, 255);
			4: return -$urandom_range(1, 255);
			5: return $urandom >> $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_vector({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
	endtask

	initial begin
		logic [2:0] dims[7] = '{3'd3, 3'd2, 3'd0, 3'd7, 3'd1, 3'd5, 3'd4};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: zero, full scale, extremes, unused lanes ignored.
		send_vector(128'd0);
		send_vector({4{32'h8000_0000}});
		send_vector({4{32'h7fff_ffff}});
		send_vector({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		send_vector({32'd0, 32'd0, 32'd0, 32'd1});
		send_vector({32'd0, 32'd0, 32'hffff_ffff, 32'd0});
		send_vector({32'd1, 32'd0, 32'd0, 32'd0});
		send_vector({32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
		send_vector({32'hffff_0000, 32'h0003_0000, 32'h0004_0000, 32'hfffd_0000});
		send_vector({32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff, 32'h0000_0001});
		set_dimension(3'd2);
		send_vector({32'h1234_5678, 32'h8000_0000, 32'd0, 32'd0});
		send_vector({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_vector({32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd3});
		// Long receiver hold-off, counted in its own process, while the sender keeps offering.
		calm = 1;
		fork
			begin
				hold <= 1;
				repeat (300) @(posedge clk);
				hold <= 0;
			end
		join_none
		random_phase(150);
		calm = 0;
		random_phase(250);
		foreach (dims[k]) begin
			set_dimension(dims[k]);
			if (k == 2)
				calm = 1;
			random_phase(190);
			calm = 0;
		end
		s_tvalid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("vector_normalize_unit test passed");
		else
			$display("vector_normalize_unit test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("vector_normalize_unit test failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/vnu_pkg.sv
src/vnu_sqrt_cell.sv
src/vnu_div_cell.sv
src/vector_normalize_unit.sv
dv/testbench.sv
